// ===== src/mfbd_pkg.sv =====
package mfbd_pkg;

    localparam int DEF_FRAME_WIDTH  = 576;
    localparam int DEF_FRAME_HEIGHT = 454;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int INDEX_W  = 18;
    localparam int COLOR_W  = 32;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CMD_QUEUE_DEPTH = 4;

    localparam logic [COLOR_W-1:0] FORE_RESET = 32'h00FF_0000;
    localparam logic [COLOR_W-1:0] BACK_RESET = 32'h0000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR = 2'd1;

    localparam logic [KIND_W-1:0] EV_PIXEL   = 2'd0;
    localparam logic [KIND_W-1:0] EV_CLOSE   = 2'd1;
    localparam logic [KIND_W-1:0] EV_UNKNOWN = 2'd2;

    localparam logic [BYTE_W-1:0] MSG_RECT  = 8'd2;
    localparam logic [BYTE_W-1:0] MSG_WORD  = 8'd3;
    localparam logic [BYTE_W-1:0] MSG_QUIT  = 8'd4;

    typedef enum logic [2:0] {
        PH_LEN_LO,
        PH_LEN_HI,
        PH_TYPE,
        PH_HEADER,
        PH_DATA,
        PH_SKIP
    } phase_t;

    // One unit of work for the expander: an event, or a data word with the
    // positions (bit k = k-th pixel, msb of the word first) that land in frame.
    typedef struct packed {
        logic                   is_event;
        logic [KIND_W-1:0]      kind;
        logic [BYTE_W-1:0]      bad_type;
        logic [WORD_W-1:0]      word;
        logic [INDEX_W-1:0]     base;
        logic [WORD_W-1:0]      mask;
    } cmd_t;

endpackage

// ===== src/mfbd_front.sv =====
module mfbd_front
    import mfbd_pkg::*;
#(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] link_byte,
    input  logic              q_full,
    output logic              push,
    output cmd_t              push_cmd
);

    localparam logic [31:0] NPIX = 32'(FRAME_WIDTH * FRAME_HEIGHT);

    phase_t              phase_reg, phase_next;
    logic [WORD_W-1:0]   bl_reg, bl_next;
    logic [BYTE_W-1:0]   type_reg, type_next;
    logic [WORD_W-1:0]   hdr_reg [4];
    logic [WORD_W-1:0]   hdr_next [4];
    logic [2:0]          fc_reg, fc_next;
    logic [BYTE_W-1:0]   hold_reg, hold_next;
    logic [WORD_W-1:0]   row_reg, row_next;
    logic [WORD_W-1:0]   wc_reg, wc_next;

    logic                accept;
    logic                consume;
    logic [3:0]          fc_inc;
    logic [WORD_W-1:0]   wc_inc;
    logic [WORD_W-1:0]   row_inc;
    logic [WORD_W-1:0]   bl_dec;

    logic [16:0]         rect_row;
    logic [20:0]         rect_col0;
    logic [31:0]         rect_prod;
    logic [WORD_W-1:0]   rect_mask;
    logic [19:0]         sw_base;
    logic [WORD_W-1:0]   sw_mask;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign fc_inc   = {1'b0, fc_reg} + 4'd1;
    assign wc_inc   = wc_reg + 16'd1;
    assign row_inc  = row_reg + 16'd1;
    assign bl_dec   = bl_reg - 16'd1;

    // Rectangle word position and in-frame pixels
    always_comb
    begin
        rect_row  = {1'b0, hdr_reg[1]} + {1'b0, row_reg};
        rect_col0 = {({1'b0, hdr_reg[0]} + {1'b0, wc_reg}), 4'b0000};
        rect_prod = 32'(rect_row) * 32'(FRAME_WIDTH);
        for (int k = 0; k < WORD_W; k++)
        begin
            rect_mask[k] = (32'(rect_row) < 32'(FRAME_HEIGHT))
                        && ((32'(rect_col0) + 32'(k)) < 32'(FRAME_WIDTH));
        end
    end

    // Single-word position uses the address as it stands after this byte
    always_comb
    begin
        sw_base = {hdr_next[0], 4'b0000};
        for (int k = 0; k < WORD_W; k++)
        begin
            sw_mask[k] = (32'(sw_base) + 32'(k)) < NPIX;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        bl_next    = bl_reg;
        type_next  = type_reg;
        hdr_next   = hdr_reg;
        fc_next    = fc_reg;
        hold_next  = hold_reg;
        row_next   = row_reg;
        wc_next    = wc_reg;
        consume    = 1'b0;
        push       = 1'b0;
        push_cmd   = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN_HI:
                begin
                    bl_next    = {link_byte, hold_reg};
                    phase_next = ({link_byte, hold_reg} != 16'd0) ? PH_TYPE : PH_LEN_LO;
                end
                PH_TYPE:
                begin
                    consume   = 1'b1;
                    type_next = link_byte;
                    fc_next   = 3'd0;
                    row_next  = '0;
                    wc_next   = '0;
                    if (link_byte == MSG_RECT || link_byte == MSG_WORD)
                    begin
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        push              = 1'b1;
                        push_cmd.is_event = 1'b1;
                        if (link_byte == MSG_QUIT)
                        begin
                            push_cmd.kind = EV_CLOSE;
                        end
                        else
                        begin
                            push_cmd.kind     = EV_UNKNOWN;
                            push_cmd.bad_type = link_byte;
                        end
                        phase_next = PH_SKIP;
                    end
                end
                PH_HEADER:
                begin
                    consume = 1'b1;
                    if (!fc_reg[0])
                    begin
                        hold_next = link_byte;
                    end
                    else
                    begin
                        hdr_next[fc_reg[2:1]] = {link_byte, hold_reg};
                    end
                    fc_next = fc_inc[2:0];
                    if (fc_inc >= ((type_reg == MSG_RECT) ? 4'd8 : 4'd4))
                    begin
                        fc_next = 3'd0;
                        if (type_reg == MSG_RECT)
                        begin
                            phase_next = (hdr_next[2] != '0 && hdr_next[3] != '0)
                                       ? PH_DATA : PH_SKIP;
                        end
                        else
                        begin
                            push          = (sw_mask != '0);
                            push_cmd.kind = EV_PIXEL;
                            push_cmd.word = hdr_next[1];
                            push_cmd.base = sw_base[INDEX_W-1:0];
                            push_cmd.mask = sw_mask;
                            phase_next    = PH_SKIP;
                        end
                    end
                end
                PH_DATA:
                begin
                    consume = 1'b1;
                    if (!fc_reg[0])
                    begin
                        hold_next = link_byte;
                        fc_next   = 3'd1;
                    end
                    else
                    begin
                        push          = (rect_mask != '0);
                        push_cmd.kind = EV_PIXEL;
                        push_cmd.word = {link_byte, hold_reg};
                        push_cmd.base = INDEX_W'(rect_prod + 32'(rect_col0));
                        push_cmd.mask = rect_mask;
                        fc_next       = 3'd0;
                        wc_next       = wc_inc;
                        if (wc_inc >= hdr_reg[2])
                        begin
                            wc_next  = '0;
                            row_next = row_inc;
                            if (row_inc >= hdr_reg[3])
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end
                PH_SKIP:
                begin
                    consume = 1'b1;
                end
                default:
                begin
                    hold_next  = link_byte;
                    phase_next = PH_LEN_HI;
                end
            endcase

            if (consume)
            begin
                bl_next = bl_dec;
                if (bl_dec == '0)
                begin
                    phase_next = PH_LEN_LO;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN_LO;
            bl_reg    <= '0;
            type_reg  <= '0;
            hdr_reg   <= '{default: '0};
            fc_reg    <= '0;
            hold_reg  <= '0;
            row_reg   <= '0;
            wc_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            bl_reg    <= bl_next;
            type_reg  <= type_next;
            hdr_reg   <= hdr_next;
            fc_reg    <= fc_next;
            hold_reg  <= hold_next;
            row_reg   <= row_next;
            wc_reg    <= wc_next;
        end
    end

endmodule

// ===== src/mfbd_queue.sv =====
module mfbd_queue
    import mfbd_pkg::*;
#(
    parameter int DEPTH = CMD_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/mfbd_back.sv =====
module mfbd_back
    import mfbd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               head,
    input  logic               empty,
    output logic               pop,
    input  logic [COLOR_W-1:0] fore_color,
    input  logic [COLOR_W-1:0] back_color,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  event_kind,
    output logic [INDEX_W-1:0] pixel_index,
    output logic [COLOR_W-1:0] pixel_color,
    output logic [BYTE_W-1:0]  bad_type,
    output logic               last_of_run
);

    logic [3:0]          k_reg, k_next;
    logic                valid_reg, valid_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [INDEX_W-1:0]  index_reg, index_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic [BYTE_W-1:0]   bad_reg, bad_next;
    logic                last_reg, last_next;

    logic                advance;
    logic                done;

    assign advance = !valid_reg || out_ready;
    // Done once no in-frame pixel remains above the current position
    assign done    = (head.mask & (16'hFFFE << k_reg)) == '0;

    always_comb
    begin
        k_next     = k_reg;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        index_next = index_reg;
        color_next = color_reg;
        bad_next   = bad_reg;
        last_next  = last_reg;
        pop        = 1'b0;

        if (advance)
        begin
            valid_next = 1'b0;
            if (!empty)
            begin
                if (head.is_event)
                begin
                    valid_next = 1'b1;
                    kind_next  = head.kind;
                    index_next = '0;
                    color_next = '0;
                    bad_next   = head.bad_type;
                    last_next  = 1'b1;
                    pop        = 1'b1;
                    k_next     = '0;
                end
                else
                begin
                    valid_next = head.mask[k_reg];
                    kind_next  = EV_PIXEL;
                    index_next = head.base + INDEX_W'(k_reg);
                    color_next = head.word[~k_reg] ? fore_color : back_color;
                    bad_next   = '0;
                    last_next  = done;
                    pop        = done;
                    k_next     = done ? 4'd0 : k_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        index_reg <= index_next;
        color_reg <= color_next;
        bad_reg   <= bad_next;
        last_reg  <= last_next;
    end

    assign out_valid   = valid_reg;
    assign event_kind  = kind_reg;
    assign pixel_index = index_reg;
    assign pixel_color = color_reg;
    assign bad_type    = bad_reg;
    assign last_of_run = last_reg;

endmodule

// ===== src/mono_framebuffer_update_decoder_unit.sv =====
// Display message decoder for a monochrome framebuffer.
// Input: one stream byte per transfer on in_valid/in_ready/link_byte.
// Output: one result per transfer on out_valid/out_ready: a pixel write
// (event_kind, pixel_index, pixel_color), a close event or an unknown-type
// event (bad_type); last_of_run marks the final result caused by one byte.
// Config: cfg_valid/cfg_ready/cfg_index/cfg_data set fore_color (index 0)
// and back_color (index 1); cfg_ready is always high.
// The parser takes one byte per cycle while the queue is not full and hands
// events and completed data words to a 4-entry command queue. The expander
// steps one bit position per cycle while out_ready does not stall it; a data
// word stops after its last in-frame pixel and an event gives one result.
// With words arriving steadily, the expander bounds the block's byte rate.
// With the queue empty, a byte's first result passes through a queue entry
// and then the output register.
// Reset clears parser state, empties the queue and restores the reset
// colors. When out_ready stays low the output register holds, the queue
// fills and in_ready drops; bytes that cause no result still need a free
// queue slot to be taken.
module mono_framebuffer_update_decoder_unit
    import mfbd_pkg::*;
#(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    link_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KIND_W-1:0]    event_kind,
    output logic [INDEX_W-1:0]   pixel_index,
    output logic [COLOR_W-1:0]   pixel_color,
    output logic [BYTE_W-1:0]    bad_type,
    output logic                 last_of_run,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    logic [COLOR_W-1:0] fore_reg;
    logic [COLOR_W-1:0] back_reg;

    logic q_push, q_pop, q_full, q_empty;
    cmd_t q_in, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_reg <= FORE_RESET;
            back_reg <= BACK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_FORE_COLOR)
            begin
                fore_reg <= cfg_data;
            end
            else if (cfg_index == CFG_BACK_COLOR)
            begin
                back_reg <= cfg_data;
            end
        end
    end

    mfbd_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .link_byte (link_byte),
        .q_full    (q_full),
        .push      (q_push),
        .push_cmd  (q_in)
    );

    mfbd_queue #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    mfbd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .empty       (q_empty),
        .pop         (q_pop),
        .fore_color  (fore_reg),
        .back_color  (back_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .pixel_index (pixel_index),
        .pixel_color (pixel_color),
        .bad_type    (bad_type),
        .last_of_run (last_of_run)
    );

    a_event_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_PIXEL |-> last_of_run)
        else $error("event result without last_of_run");

    a_bad_type_only_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_UNKNOWN |-> bad_type == '0)
        else $error("bad_type set on a non-unknown result");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from an empty queue");

endmodule
